// File: hw/rtl/crc5_sensor_link_receiver_defines.svh
// Assertion macros for the CRC-5 sensor link receiver.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef CRC5_SENSOR_LINK_RECEIVER_DEFINES_SVH
`define CRC5_SENSOR_LINK_RECEIVER_DEFINES_SVH

// same-cycle implication
`define CRC5SL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crc5sl assertion failed");

// next-cycle implication
`define CRC5SL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crc5sl assertion failed");

`endif

// File: hw/rtl/crc5sl_pkg.sv
// Types, codes and CRC-5 functions for the CRC-5 sensor link receiver.
// No dependencies.
package crc5sl_pkg;

   localparam logic [7:0]  GEN8      = 8'hD4;
   localparam logic [15:0] GEN16     = 16'(53 << 10);
   localparam logic [7:0]  CODE_MASK = 8'h60;
   localparam logic [7:0]  CODE_LOG  = 8'h20;
   localparam logic [7:0]  CODE_ACK  = 8'h40;
   localparam logic [7:0]  CODE_RPT  = 8'h60;
   localparam logic [7:0]  CODE_RST  = 8'h00;

   localparam logic [15:0] LOG_START_RST = 16'h0500;
   localparam logic [15:0] LOG_GAP_RST   = 16'h10EB;
   localparam logic [15:0] EXT_START_RST = 16'h1100;
   localparam logic [15:0] EXT_END_RST   = 16'h18FF;

   typedef enum logic [1:0] {
      REG_LOG_START = 2'd0,
      REG_LOG_GAP   = 2'd1,
      REG_EXT_START = 2'd2,
      REG_EXT_END   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] log_start;
      logic [15:0] log_gap_start;
      logic [15:0] ext_start;
      logic [15:0] ext_end;
   } cfg_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        log_valid;
      logic [15:0] log_addr;
      logic [7:0]  log_data;
      logic        log_external;
      logic        reset_issued;
      logic        readout_request;
      logic        crc_error;
   } rsp_type;

   // 3-bit header shifted through the generator, remainder placed in bits 4..0
   function automatic logic [7:0] crc3_append(input logic [7:0] b);
      logic [7:0] t;
      t = b;
      for (int k = 0; k < 3; k++) begin
         if (t[7]) t = t ^ GEN8;
         t = {t[6:0], 1'b0};
      end
      return b | {3'b000, t[7:3]};
   endfunction

   function automatic logic crc_byte_ok(input logic [7:0] b);
      logic [7:0] t;
      t = b;
      for (int k = 0; k < 3; k++) begin
         if (t[7]) t = t ^ GEN8;
         t = {t[6:0], 1'b0};
      end
      return t == 8'h00;
   endfunction

   // fixed XOR network over the data/command pair
   function automatic logic crc_word_ok(input logic [7:0] hi, input logic [7:0] lo);
      logic [15:0] t;
      t = {hi, lo};
      for (int k = 0; k < 11; k++) begin
         if (t[15]) t = t ^ GEN16;
         t = {t[14:0], 1'b0};
      end
      return t == 16'h0000;
   endfunction

   localparam logic [7:0] TX_REPEAT = crc3_append(CODE_RPT);
   localparam logic [7:0] TX_ACK    = crc3_append(CODE_ACK);
   localparam logic [7:0] TX_RESET  = crc3_append(CODE_RST);

endpackage

// File: hw/rtl/crc5sl_decode.sv
// Per-transaction decode: CRC check, command handling, log pointer stepping.
// Depends on crc5sl_pkg.
module crc5sl_decode #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            tos,
   input  logic [ADDR_WIDTH-1:0] ptr,
   input  crc5sl_pkg::cfg_type   cfg,
   output logic [7:0]            tos_next,
   output logic [ADDR_WIDTH-1:0] ptr_next,
   output crc5sl_pkg::rsp_type   rsp
);
   import crc5sl_pkg::*;

   localparam int W = (ADDR_WIDTH > 17) ? ADDR_WIDTH : 17;

   logic [W-1:0]          ext_end_inc;
   logic [ADDR_WIDTH-1:0] p_sel;
   logic [W-1:0]          p_wide;
   logic                  p_ext;
   logic [7:0]            code;

   assign code        = rx_byte & CODE_MASK;
   assign ext_end_inc = W'(cfg.ext_end) + W'(1);

   always_comb begin
      if (ptr == ADDR_WIDTH'(cfg.log_gap_start)) begin
         p_sel = ADDR_WIDTH'(cfg.ext_start);
      end else if (ptr == ADDR_WIDTH'(ext_end_inc)) begin
         p_sel = ADDR_WIDTH'(cfg.log_start);
      end else begin
         p_sel = ptr;
      end
   end

   assign p_wide = W'(p_sel);
   assign p_ext  = (p_wide >= W'(cfg.ext_start)) && (p_wide <= W'(cfg.ext_end));

   always_comb begin
      rsp      = '0;
      tos_next = tos;
      ptr_next = ptr;
      if (rx_byte[7]) begin
         tos_next = rx_byte;
      end else if (tos[7]) begin
         if (!crc_word_ok(tos, rx_byte)) begin
            tos_next      = '0;
            rsp.tx_valid  = 1'b1;
            rsp.tx_byte   = TX_REPEAT;
            rsp.crc_error = 1'b1;
         end else if (code == CODE_LOG) begin
            rsp.log_valid    = 1'b1;
            rsp.log_addr     = 16'(p_sel);
            rsp.log_data     = tos;
            rsp.log_external = p_ext;
            ptr_next         = p_sel + ADDR_WIDTH'(1);
            tos_next         = TX_ACK;
            rsp.tx_valid     = 1'b1;
            rsp.tx_byte      = TX_ACK;
         end else begin
            ptr_next         = ADDR_WIDTH'(cfg.log_start);
            tos_next         = TX_RESET;
            rsp.tx_valid     = 1'b1;
            rsp.tx_byte      = TX_RESET;
            rsp.reset_issued = 1'b1;
         end
      end else begin
         if (!crc_byte_ok(rx_byte)) begin
            rsp.tx_valid  = 1'b1;
            rsp.tx_byte   = TX_REPEAT;
            rsp.crc_error = 1'b1;
         end else if (code == CODE_ACK) begin
            if (tos != 8'h00) tos_next = '0;
            else rsp.readout_request = 1'b1;
         end else if (code == CODE_RPT) begin
            if (tos != 8'h00) begin
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = tos;
            end
         end
      end
   end

endmodule

// File: hw/rtl/crc5_sensor_link_receiver.sv
// CRC-5 sensor link receiver top level: config registers, link state, output buffer.
// Depends on crc5sl_pkg, crc5sl_decode and crc5_sensor_link_receiver_defines.svh.
//
// Usage:
//   req_ channel: one received link byte per transaction (req_rx_byte).
//   rsp_ channel: exactly one result transaction per request: the reply byte
//     (tx), an optional log memory write, and status flags.
//   csr_ channel: register writes (index 0..3: log_start, log_gap_start,
//     ext_start, ext_end); always ready, write only while the block is idle.
// Results: each result is registered, in the skid register while another waits.
// Throughput: one transaction per cycle while req_ready is high; the decode
//   is a single pass of CRC XOR network and pointer compare between the
//   accept edge and the result register.
// Stall: a two-entry output buffer (result register plus skid register)
//   lets one more request in while a result waits; req_ready drops only
//   when both entries are full.
// Reset: registers return to their defaults, the held byte clears, the log
//   pointer goes to the log_start default and both output entries empty.
module crc5_sensor_link_receiver #(
   parameter int ADDR_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_log_valid,
   output logic [15:0] rsp_log_addr,
   output logic [7:0]  rsp_log_data,
   output logic        rsp_log_external,
   output logic        rsp_reset_issued,
   output logic        rsp_readout_request,
   output logic        rsp_crc_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import crc5sl_pkg::*;
   `include "crc5_sensor_link_receiver_defines.svh"

   cfg_type               cfg_ff;
   logic [7:0]            tos_ff;
   logic [ADDR_WIDTH-1:0] ptr_ff;
   logic [7:0]            tos_in;
   logic [ADDR_WIDTH-1:0] ptr_in;
   rsp_type               res;
   rsp_type               out_ff;
   rsp_type               skid_ff;
   logic                  out_valid_ff;
   logic                  skid_valid_ff;
   logic                  req_take;
   logic                  rsp_take;
   csr_index_type         csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);
   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_take  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_start     <= LOG_START_RST;
         cfg_ff.log_gap_start <= LOG_GAP_RST;
         cfg_ff.ext_start     <= EXT_START_RST;
         cfg_ff.ext_end       <= EXT_END_RST;
      end else if (csr_valid) begin
         unique case (csr_sel)
            REG_LOG_START: cfg_ff.log_start     <= csr_data;
            REG_LOG_GAP:   cfg_ff.log_gap_start <= csr_data;
            REG_EXT_START: cfg_ff.ext_start     <= csr_data;
            REG_EXT_END:   cfg_ff.ext_end       <= csr_data;
            default: ;
         endcase
      end
   end

   crc5sl_decode #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_decode (
      .rx_byte (req_rx_byte),
      .tos     (tos_ff),
      .ptr     (ptr_ff),
      .cfg     (cfg_ff),
      .tos_next(tos_in),
      .ptr_next(ptr_in),
      .rsp     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tos_ff <= '0;
         ptr_ff <= ADDR_WIDTH'(LOG_START_RST);
      end else if (req_take) begin
         tos_ff <= tos_in;
         ptr_ff <= ptr_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take) begin
            if (out_valid_ff && !rsp_ready) skid_valid_ff <= 1'b1;
            else out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_ff <= skid_ff;
      end else if (req_take) begin
         if (out_valid_ff && !rsp_ready) skid_ff <= res;
         else out_ff <= res;
      end
   end

   assign rsp_tx_valid        = out_ff.tx_valid;
   assign rsp_tx_byte         = out_ff.tx_byte;
   assign rsp_log_valid       = out_ff.log_valid;
   assign rsp_log_addr        = out_ff.log_addr;
   assign rsp_log_data        = out_ff.log_data;
   assign rsp_log_external    = out_ff.log_external;
   assign rsp_reset_issued    = out_ff.reset_issued;
   assign rsp_readout_request = out_ff.readout_request;
   assign rsp_crc_error       = out_ff.crc_error;

   `CRC5SL_ASSERT_IMPL(a_skid_needs_out, skid_valid_ff, out_valid_ff)
   `CRC5SL_ASSERT_IMPL(a_log_sends_ack, out_valid_ff && out_ff.log_valid,
      out_ff.tx_valid && (out_ff.tx_byte == TX_ACK))
   `CRC5SL_ASSERT_NEXT(a_data_held, req_take && req_rx_byte[7],
      tos_ff == $past(req_rx_byte))

endmodule

// File: tb/sv/crc5_sensor_link_receiver_checker.sv
// Watches the request, response and register channels of the CRC-5 sensor link receiver,
// predicts every reply from its own copy of the link state and compares field by field.
// Depends on crc5sl_pkg for codes, register indexes, reset values and the reply struct.
`timescale 1ns / 100ps

module crc5_sensor_link_receiver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_tx_valid,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_log_valid,
   input  logic [15:0] rsp_log_addr,
   input  logic [7:0]  rsp_log_data,
   input  logic        rsp_log_external,
   input  logic        rsp_reset_issued,
   input  logic        rsp_readout_request,
   input  logic        rsp_crc_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          outstanding
);
   import crc5sl_pkg::*;

   cfg_type     link_cfg;
   logic [7:0]  held_byte;
   logic [15:0] log_ptr;
   rsp_type     pending_replies[$];
   int          rx_accepted;
   int          replies_seen;

   assign outstanding = rx_accepted - replies_seen;

   // long division by x^5+x^4+x^2+1
   function automatic logic [4:0] crc5_remainder(input logic [15:0] w);
      logic [15:0] t;
      t = w;
      for (int i = 15; i >= 5; i--)
         if (t[i]) t = t ^ (16'b110101 << (i - 5));
      return t[4:0];
   endfunction

   function automatic logic [7:0] with_crc(input logic [7:0] code);
      return code | {3'b000, crc5_remainder({8'h00, code})};
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
   endtask

   task automatic predict_link_reply(input logic [7:0] rx);
      rsp_type     r;
      logic [15:0] p;
      r = '0;
      if (rx[7]) begin
         held_byte = rx;
      end else if (held_byte[7]) begin
         if (crc5_remainder({held_byte, rx}) != 5'd0) begin
            held_byte   = 8'h00;
            r.tx_valid  = 1'b1;
            r.tx_byte   = with_crc(CODE_RPT);
            r.crc_error = 1'b1;
         end else if ((rx & CODE_MASK) == CODE_LOG) begin
            p = log_ptr;
            if (p == link_cfg.log_gap_start) p = link_cfg.ext_start;
            else if (p == 16'(link_cfg.ext_end + 1)) p = link_cfg.log_start;
            r.log_valid    = 1'b1;
            r.log_addr     = p;
            r.log_data     = held_byte;
            r.log_external = (p >= link_cfg.ext_start) && (p <= link_cfg.ext_end);
            log_ptr        = p + 16'd1;
            held_byte      = with_crc(CODE_ACK);
            r.tx_valid     = 1'b1;
            r.tx_byte      = held_byte;
         end else begin
            log_ptr        = link_cfg.log_start;
            held_byte      = with_crc(CODE_RST);
            r.tx_valid     = 1'b1;
            r.tx_byte      = held_byte;
            r.reset_issued = 1'b1;
         end
      end else begin
         if (crc5_remainder({8'h00, rx}) != 5'd0) begin
            r.tx_valid  = 1'b1;
            r.tx_byte   = with_crc(CODE_RPT);
            r.crc_error = 1'b1;
         end else if ((rx & CODE_MASK) == CODE_ACK) begin
            if (held_byte != 8'h00) held_byte = 8'h00;
            else r.readout_request = 1'b1;
         end else if ((rx & CODE_MASK) == CODE_RPT && held_byte != 8'h00) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = held_byte;
         end
      end
      pending_replies.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         link_cfg     = '{log_start: LOG_START_RST, log_gap_start: LOG_GAP_RST,
                          ext_start: EXT_START_RST, ext_end: EXT_END_RST};
         held_byte    = 8'h00;
         log_ptr      = LOG_START_RST;
         pending_replies.delete();
         rx_accepted  = 0;
         replies_seen = 0;
         fail_count   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LOG_START: link_cfg.log_start     = csr_data;
               REG_LOG_GAP:   link_cfg.log_gap_start = csr_data;
               REG_EXT_START: link_cfg.ext_start     = csr_data;
               REG_EXT_END:   link_cfg.ext_end       = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_link_reply(req_rx_byte);
            rx_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               report_mismatch("response transaction with no prediction pending");
            end else begin
               want = pending_replies.pop_front();
               check_field("tx_valid", 16'(rsp_tx_valid), 16'(want.tx_valid));
               check_field("tx_byte", 16'(rsp_tx_byte), 16'(want.tx_byte));
               check_field("log_valid", 16'(rsp_log_valid), 16'(want.log_valid));
               check_field("log_addr", rsp_log_addr, want.log_addr);
               check_field("log_data", 16'(rsp_log_data), 16'(want.log_data));
               check_field("log_external", 16'(rsp_log_external),
                           16'(want.log_external));
               check_field("reset_issued", 16'(rsp_reset_issued),
                           16'(want.reset_issued));
               check_field("readout_request", 16'(rsp_readout_request),
                           16'(want.readout_request));
               check_field("crc_error", 16'(rsp_crc_error), 16'(want.crc_error));
            end
         end
      end
   end

endmodule

// File: tb/sv/crc5_sensor_link_receiver_tb.sv
// Top of the CRC-5 sensor link receiver testbench: clock, reset, stimulus, flow control, verdict.
// Depends on crc5sl_pkg, the block and crc5_sensor_link_receiver_checker.
`timescale 1ns / 100ps

module crc5_sensor_link_receiver_tb;
   import crc5sl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_log_valid;
   logic [15:0] rsp_log_addr;
   logic [7:0]  rsp_log_data;
   logic        rsp_log_external;
   logic        rsp_reset_issued;
   logic        rsp_readout_request;
   logic        rsp_crc_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'h0000;

   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   hold_left = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;

   crc5_sensor_link_receiver uut (.*);

   crc5_sensor_link_receiver_checker link_monitor (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // serial CRC-5 over {hi, code[7:5]}
   function automatic logic [7:0] command_byte(input logic [7:0] hi, input logic [7:0] code);
      logic [10:0] msg;
      logic [4:0]  crc;
      logic        fb;
      msg = {hi, code[7:5]};
      crc = '0;
      for (int i = 10; i >= 0; i--) begin
         fb  = msg[i] ^ crc[4];
         crc = {crc[3:0], 1'b0} ^ (fb ? 5'b10101 : 5'b00000);
      end
      return {code[7:5], crc};
   endfunction

   function automatic logic [7:0] random_code();
      return {1'b0, 2'($urandom_range(0, 3)), 5'b00000};
   endfunction

   task automatic send_rx(input logic [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] start, input logic [15:0] gap,
                            input logic [15:0] ext_lo, input logic [15:0] ext_hi);
      write_csr(REG_LOG_START, start);
      write_csr(REG_LOG_GAP, gap);
      write_csr(REG_EXT_START, ext_lo);
      write_csr(REG_EXT_END, ext_hi);
      csr_valid <= 1'b0;
   endtask

   // mostly data byte + command pairs, some corrupted, plus noise
   task automatic random_burst();
      int          kind;
      logic [7:0]  hi;
      logic [7:0]  code;
      logic [7:0]  cmd;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         hi = {1'b1, 7'($urandom)};
         send_rx(hi);
         code = ($urandom_range(0, 99) < 85) ? CODE_LOG : random_code();
         cmd  = command_byte(hi, code);
         if ($urandom_range(0, 99) < 10) cmd = cmd ^ (8'h01 << $urandom_range(0, 6));
         send_rx(cmd);
         if ($urandom_range(0, 99) < 40)
            send_rx(command_byte(8'h00, $urandom_range(0, 1) ? CODE_ACK : CODE_RPT));
      end else if (kind < 90) begin
         send_rx(8'($urandom));
      end else begin
         cmd = command_byte(8'h00, random_code());
         if ($urandom_range(0, 1)) cmd = cmd ^ (8'h01 << $urandom_range(0, 6));
         send_rx(cmd);
      end
   endtask

   task automatic run_items(input int n);
      int start;
      start = items_sent;
      while (items_sent - start < n) random_burst();
   endtask

   initial begin
      int          phase;
      logic [15:0] base_a;
      logic [15:0] base_b;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_rx(8'h00);
      send_rx(8'h7F);
      send_rx(command_byte(8'h00, CODE_ACK));
      send_rx(command_byte(8'h00, CODE_RPT));
      send_rx(8'hFF);
      send_rx(command_byte(8'hFF, CODE_LOG));
      send_rx(command_byte(8'h00, CODE_RPT));
      send_rx(command_byte(8'h00, CODE_ACK));
      send_rx(8'h80);
      send_rx(command_byte(8'h80, CODE_RST));
      send_rx(8'hC3);
      send_rx(command_byte(8'hC3, CODE_ACK));
      send_rx(8'hA5);
      send_rx(command_byte(8'hA5, CODE_RPT));
      send_rx(8'h9A);
      send_rx(command_byte(8'h9A, CODE_LOG) ^ 8'h01);
      send_rx(command_byte(8'h00, CODE_LOG) ^ 8'h04);
      send_rx(command_byte(8'h00, CODE_LOG));
      send_rx(command_byte(8'h00, CODE_RST));
      send_rx(8'hFE);
      send_rx(8'h81);
      send_rx(command_byte(8'h81, CODE_LOG));
      send_rx(command_byte(8'h81, CODE_LOG));
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin idle_pct <= 0;  stall_pct <= 0;  end
            1: begin idle_pct <= 67; stall_pct <= 0;  end
            2: begin idle_pct <= 0;  stall_pct <= 67; end
            default: begin idle_pct <= 31; stall_pct <= 31; end
         endcase
         case (phase)
            1: configure(16'h0010, 16'h0012, 16'h0100, 16'h0101);
            2: configure(16'h0000, 16'h0003, 16'hFFFC, 16'hFFFF);
            3: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            4: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            5: begin
               base_a = 16'($urandom);
               base_b = 16'($urandom);
               configure(base_a, base_a + 16'($urandom_range(0, 6)),
                         base_b, base_b + 16'($urandom_range(0, 6)));
            end
            default: ;
         endcase
         if (phase == 0) hold_toggle <= ~hold_toggle;
         if (phase == 2) begin
            run_items(100);
            settle();
            run_items(100);
         end else begin
            run_items(200);
         end
         settle();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
